>>> rtl/http_header_tokenizer_assert.svh
// assertion macros for the header tokenizer
`ifndef HTTP_HEADER_TOKENIZER_ASSERT_SVH
`define HTTP_HEADER_TOKENIZER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define HTT_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define HTT_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/htt_pkg.sv
// shared types and constants of the header tokenizer
`timescale 1ns / 1ps
package htt_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [15:0] CAP_RESET = 16'd8192;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] NAME_LO  = 8'd33;
  localparam logic [7:0] NAME_HI  = 8'd126;

  typedef logic [2:0] tok_kind_t;
  localparam tok_kind_t TK_NAME  = 3'd0;
  localparam tok_kind_t TK_BODY  = 3'd1;
  localparam tok_kind_t TK_FIELD = 3'd2;
  localparam tok_kind_t TK_END   = 3'd3;
  localparam tok_kind_t TK_BAD   = 3'd4;
  localparam tok_kind_t TK_BIG   = 3'd5;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] tbyte;
  } tok_t;

  // tokens caused by one input byte, count is 1 or 2
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } q_entry_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QAW:0]   cnt;
  } q_stat_t;

  function automatic tok_t mk_tok(tok_kind_t k, logic [7:0] b);
    tok_t t;
    t.kind  = k;
    t.tbyte = b;
    return t;
  endfunction

endpackage

>>> rtl/htt_in_if.sv
// input byte channel
`timescale 1ns / 1ps
interface htt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

>>> rtl/htt_out_if.sv
// token result channel
`timescale 1ns / 1ps
interface htt_out_if import htt_pkg::*;;
  logic       valid;
  logic       ready;
  tok_kind_t  token_kind;
  logic [7:0] token_byte;
  logic       last;

  modport source (output valid, output token_kind, output token_byte, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_byte, input last,
                  output ready);
endinterface

>>> rtl/htt_front.sv
// front end: header grammar state, storage accounting, token generation
`timescale 1ns / 1ps
module htt_front import htt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        kind,
  input  logic [7:0]  in_byte,
  input  logic [15:0] capacity,
  output logic        push,
  output q_entry_t    entry
);

  typedef enum logic [3:0] {
    S_START, S_CR, S_NAME, S_NAMESP, S_BODY0, S_BODY, S_BODYCR, S_LINEEND, S_ENDCR
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] used_r, used_nxt;
  logic        fin_r, fin_nxt;

  logic        is_ws, is_name, ok1, ok2;
  logic [1:0]  n;
  tok_t        t0, t1;
  logic [7:0]  c;

  assign c       = in_byte;
  assign is_ws   = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  assign is_name = (c >= NAME_LO) && (c <= NAME_HI);
  assign ok1     = ({1'b0, used_r} + 17'd1) < {1'b0, capacity};
  assign ok2     = ({1'b0, used_r} + 17'd2) < {1'b0, capacity};

  always_comb begin
    n         = 2'd0;
    t0        = mk_tok(TK_NAME, CH_NUL);
    t1        = mk_tok(TK_NAME, CH_NUL);
    state_nxt = state_r;
    used_nxt  = used_r;
    fin_nxt   = fin_r;
    if (kind) begin
      state_nxt = S_START;
      used_nxt  = '0;
      fin_nxt   = 1'b0;
    end else if (!fin_r) begin
      case (state_r)
        S_START: begin
          if (is_name && c != CH_COLON) begin
            n = 2'd1;
            if (ok1) begin
              used_nxt  = used_r + 16'd1;
              t0        = mk_tok(TK_NAME, c);
              state_nxt = S_NAME;
            end else begin
              t0      = mk_tok(TK_BIG, CH_NUL);
              fin_nxt = 1'b1;
            end
          end else if (c == CH_LF) begin
            n       = 2'd1;
            t0      = mk_tok(TK_END, CH_NUL);
            fin_nxt = 1'b1;
          end else if (c == CH_CR) begin
            state_nxt = S_CR;
          end else if (!is_ws) begin
            n       = 2'd1;
            t0      = mk_tok(TK_BAD, CH_NUL);
            fin_nxt = 1'b1;
          end
        end
        S_CR: begin
          n       = 2'd1;
          fin_nxt = 1'b1;
          t0      = (c == CH_LF) ? mk_tok(TK_END, CH_NUL) : mk_tok(TK_BAD, CH_NUL);
        end
        S_NAME: begin
          if (c == CH_COLON || is_ws) begin
            // separator takes two storage bytes and makes no token, or a TK_BIG token if storage runs out
            if (ok2) begin
              used_nxt  = used_r + 16'd2;
              state_nxt = (c == CH_COLON) ? S_BODY0 : S_NAMESP;
            end else begin
              n       = 2'd1;
              t0      = mk_tok(TK_BIG, CH_NUL);
              fin_nxt = 1'b1;
            end
          end else if (is_name) begin
            n = 2'd1;
            if (ok1) begin
              used_nxt = used_r + 16'd1;
              t0       = mk_tok(TK_NAME, c);
            end else begin
              t0      = mk_tok(TK_BIG, CH_NUL);
              fin_nxt = 1'b1;
            end
          end else begin
            n       = 2'd1;
            t0      = mk_tok(TK_BAD, CH_NUL);
            fin_nxt = 1'b1;
          end
        end
        S_NAMESP: begin
          if (c == CH_COLON) begin
            state_nxt = S_BODY0;
          end else if (!is_ws) begin
            n       = 2'd1;
            t0      = mk_tok(TK_BAD, CH_NUL);
            fin_nxt = 1'b1;
          end
        end
        S_BODY0, S_BODY: begin
          if (c == CH_CR || c == CH_LF || state_r == S_BODY || !is_ws) begin
            if (ok1) begin
              used_nxt = used_r + 16'd1;
              if (c == CH_CR) begin
                state_nxt = S_BODYCR;
              end else if (c == CH_LF) begin
                state_nxt = S_LINEEND;
              end else begin
                n         = 2'd1;
                t0        = mk_tok(TK_BODY, c);
                state_nxt = S_BODY;
              end
            end else begin
              n       = 2'd1;
              t0      = mk_tok(TK_BIG, CH_NUL);
              fin_nxt = 1'b1;
            end
          end
        end
        S_BODYCR: begin
          if (c == CH_LF) begin
            state_nxt = S_LINEEND;
          end else begin
            n       = 2'd1;
            t0      = mk_tok(TK_BAD, CH_NUL);
            fin_nxt = 1'b1;
          end
        end
        S_LINEEND: begin
          if (c == CH_CR) begin
            state_nxt = S_ENDCR;
          end else if (c == CH_LF) begin
            n       = 2'd2;
            t0      = mk_tok(TK_FIELD, CH_NUL);
            t1      = mk_tok(TK_END, CH_NUL);
            fin_nxt = 1'b1;
          end else if (is_ws) begin
            // continuation line folds in as newline plus the blank
            if (ok1) begin
              used_nxt  = used_r + 16'd1;
              n         = 2'd2;
              t0        = mk_tok(TK_BODY, CH_LF);
              t1        = mk_tok(TK_BODY, c);
              state_nxt = S_BODY;
            end else begin
              n       = 2'd1;
              t0      = mk_tok(TK_BIG, CH_NUL);
              fin_nxt = 1'b1;
            end
          end else if (is_name) begin
            n  = 2'd2;
            t0 = mk_tok(TK_FIELD, CH_NUL);
            if (ok1) begin
              used_nxt  = used_r + 16'd1;
              t1        = mk_tok(TK_NAME, c);
              state_nxt = S_NAME;
            end else begin
              t1      = mk_tok(TK_BIG, CH_NUL);
              fin_nxt = 1'b1;
            end
          end
        end
        S_ENDCR: begin
          n       = (c == CH_LF) ? 2'd2 : 2'd1;
          fin_nxt = 1'b1;
          if (c == CH_LF) begin
            t0 = mk_tok(TK_FIELD, CH_NUL);
            t1 = mk_tok(TK_END, CH_NUL);
          end else begin
            t0 = mk_tok(TK_BAD, CH_NUL);
          end
        end
        default: begin
          state_nxt = S_START;
        end
      endcase
    end
  end

  assign push     = accept && (n != 2'd0);
  assign entry.cnt = n;
  assign entry.t0  = t0;
  assign entry.t1  = t1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      used_r  <= '0;
      fin_r   <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

>>> rtl/htt_queue.sv
// small queue of per-byte token groups between front and back
`timescale 1ns / 1ps
module htt_queue import htt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  q_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;

  assign stat.cnt   = cnt_r;
  assign stat.full  = (cnt_r == QDEPTH[QAW:0]);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + {{QAW{1'b0}}, do_push} - {{QAW{1'b0}}, pop};
    end
  end

endmodule

>>> rtl/htt_back.sv
// back end: splits token groups into single tokens behind an output register
`timescale 1ns / 1ps
module htt_back import htt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  q_stat_t    stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output tok_kind_t  out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       phase_r, phase_nxt;
  logic       valid_r;
  tok_t       tok_r;
  logic       last_r;
  logic       load, sel_last;
  tok_t       sel_tok;

  assign load     = (!valid_r || out_ready) && !stat.empty;
  assign sel_tok  = phase_r ? head.t1 : head.t0;
  assign sel_last = phase_r || (head.cnt == 2'd1);
  assign pop      = load && sel_last;
  assign phase_nxt = load ? !sel_last : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= sel_tok;
      last_r <= sel_last;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = tok_r.kind;
  assign out_byte  = tok_r.tbyte;
  assign out_last  = last_r;

endmodule

>>> rtl/http_header_tokenizer.sv
// top level of the http header tokenizer
// path: an accepted byte's token group is written into the token queue, then its tokens go through the output register
// throughput: one byte per cycle while the queue has room; a byte that yields two tokens sends them one after the other
// the front stalls only when the four-entry token queue is full
// reset: synchronous active-low rst_n clears the parser, byte count and queue,
// and sets the capacity register back to 8192
`timescale 1ns / 1ps
`include "http_header_tokenizer_assert.svh"
module http_header_tokenizer import htt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  htt_in_if.sink       in_ch,
  htt_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // capacity register, the only configuration register (byte addresses 0 to 3, address bit 2 clear)
  logic [15:0] cap_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[15:0];
    end
  end

  // front/back split: the queue holds the token group of each byte
  q_entry_t entry, head;
  q_stat_t  q_stat;
  logic     push, pop, in_accept;

  // a byte is taken whenever the queue has room for its group
  assign in_ch.ready = !q_stat.full;
  assign in_accept   = in_ch.valid && !q_stat.full;

  // grammar walker: state, storage count and tokens for one byte per cycle while the queue has room
  htt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .kind     (in_ch.kind),
    .in_byte  (in_ch.in_byte),
    .capacity (cap_r),
    .push     (push),
    .entry    (entry)
  );

  htt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // serializer: one token per output transaction, last marks a byte's final token
  htt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (q_stat),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.token_kind),
    .out_byte  (out_ch.token_byte),
    .out_last  (out_ch.last)
  );

  // queue bookkeeping checks
  `HTT_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "token group pushed into full queue")
  `HTT_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "token group popped from empty queue")
  `HTT_ASSERT_NOW(a_cnt_bound, 1'b1, q_stat.cnt <= QDEPTH[QAW:0], "queue count beyond depth")
  `HTT_ASSERT_NEXT(a_pop_delivers, pop, out_ch.valid && out_ch.last, "popped group not closed by last")

endmodule
